// ----- rtl/icr_pkg.sv -----
// Shared types and constants for the impulse collision resolver.
`timescale 1ns / 1ps

package icr_pkg;

    localparam int POS_W  = 32;
    localparam int VEL_W  = 32;
    localparam int REST_W = 17;
    localparam int IM_W   = 32;
    localparam int DIF_W  = POS_W + 1;
    localparam int DMAG_W = POS_W;
    localparam int LEN_W  = 32;
    localparam int VN_W   = 34;
    localparam int MUL_W  = 34;
    localparam int DIV_W  = 64;
    localparam int DVS_W  = IM_W + 1;
    localparam int SQ_W   = 64;
    localparam int CAP_W  = 41;
    localparam logic [CAP_W-1:0] MAG_CAP = CAP_W'(64'h100_0000_0000);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic [REST_W-1:0]       restitution;
        logic [IM_W-1:0]         inv_mass;
    } in_t;

    typedef struct packed {
        logic                    body_sel;
        logic signed [VEL_W-1:0] new_vel_x;
        logic signed [VEL_W-1:0] new_vel_y;
        logic signed [VEL_W-1:0] new_vel_z;
        logic                    impulse_applied;
        logic                    clipped;
        logic                    last_of_pair;
    } out_t;

    typedef enum logic [2:0] {
        MOP_SQ     = 3'd0,
        MOP_VN     = 3'd1,
        MOP_ONEPE  = 3'd2,
        MOP_IMP_LO = 3'd3,
        MOP_IMP_HI = 3'd4,
        MOP_DV_LO  = 3'd5,
        MOP_DV_HI  = 3'd6
    } mop_t;

    typedef struct packed {
        logic       load_first;
        logic       load_second;
        logic       diff;
        logic       mul_en;
        mop_t       mop;
        logic [1:0] idx;
        logic       body;
        logic       acc_clr;
        logic       sqrt_start;
        logic       div_start;
        logic       div_j;
        logic       take_len;
        logic       take_n;
        logic       take_vn;
        logic       take_j;
        logic       take_imp;
        logic       take_dv;
        logic       out_body;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic vn_pos;
        logic sqrt_done;
        logic div_done;
    } sts_t;

endpackage

// ----- rtl/icr_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module icr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [icr_pkg::DIV_W-1:0] dividend,
    input  logic [icr_pkg::DVS_W-1:0] divisor,
    output logic [icr_pkg::DIV_W-1:0] quo,
    output logic                      done
);
    import icr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CNT_W'(DIV_W);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            // The remainder always stays below the divisor, so it fits DVS_W bits.
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

// ----- rtl/icr_sqrt.sv -----
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module icr_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [icr_pkg::SQ_W-1:0]  radicand,
    output logic [icr_pkg::LEN_W-1:0] root,
    output logic                      done
);
    import icr_pkg::*;

    localparam int STEPS = SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [SQ_W-1:0]  x_reg;
    logic [SQ_W-1:0]  r_reg;
    logic [SQ_W-1:0]  bit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [SQ_W-1:0]  trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CNT_W'(STEPS);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (cnt_reg != '0)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = r_reg[LEN_W-1:0];
    assign done = done_reg;

endmodule

// ----- rtl/icr_dp.sv -----
// Datapath: pair registers, shared multiply-accumulate, root and divide units.
`timescale 1ns / 1ps

module icr_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  icr_pkg::cmd_t cmd,
    input  icr_pkg::in_t  body,
    output icr_pkg::sts_t sts,
    output icr_pkg::out_t result
);
    import icr_pkg::*;

    localparam int NW    = FRAC_BITS + 1;
    localparam int OPE_W = ((FRAC_BITS > REST_W) ? FRAC_BITS : REST_W) + 1;
    localparam int JW    = OPE_W + VN_W;
    localparam int ACC_A = JW + NW + 1;
    localparam int ACC_B = CAP_W + IM_W + 1;
    localparam int ACC_W = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int SUM_W = CAP_W + 2;

    // First body of the pair.
    logic signed [POS_W-1:0] pos0_reg [3];
    logic signed [VEL_W-1:0] vel0_reg [3];
    logic [REST_W-1:0]       rest0_reg;
    logic [IM_W-1:0]         im0_reg;
    // Second body and pair quantities.
    logic signed [VEL_W-1:0] vel1_reg [3];
    logic [IM_W-1:0]         im1_reg;
    logic [DVS_W-1:0]        imsum_reg;
    logic [OPE_W-1:0]        onepe_reg;
    logic signed [DIF_W-1:0] d_reg [3];
    logic [DIF_W-1:0]        dvmag_reg [3];
    logic                    dvneg_reg [3];
    logic [DMAG_W-1:0]       dmag_reg [3];
    logic                    dneg_reg [3];
    logic [LEN_W-1:0]        len_reg;
    logic [NW-1:0]           nmag_reg [3];
    logic [VN_W-1:0]         vn_reg;
    logic [JW-1:0]           j_reg;
    logic [CAP_W-1:0]        imp_reg;
    logic signed [VEL_W-1:0] nv0_reg [3];
    logic signed [VEL_W-1:0] nv1_reg [3];
    logic                    applied_reg;
    logic                    c0_reg;
    logic                    c1_reg;

    // Multiply-accumulate pipeline.
    logic [2*MUL_W-1:0] prod_reg;
    logic               pv_reg;
    logic               psh_reg;
    logic               pneg_reg;
    logic               pclr_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [MUL_W-1:0]   op_a;
    logic [MUL_W-1:0]   op_b;
    logic               op_sh;
    logic               op_neg;
    logic [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   acc_base;
    logic               acc_neg;
    logic [ACC_W-1:0]   acc_mag;
    logic [ACC_W-1:0]   acc_shr;
    logic [CAP_W-1:0]   capped;

    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [DIV_W-1:0]   div_quo;
    logic               div_done;
    logic [LEN_W-1:0]   sq_root;
    logic               sq_done;

    logic signed [DIF_W-1:0] d_next [3];
    logic signed [DIF_W-1:0] dv_next [3];
    logic [DIF_W-1:0]        dmag_full [3];
    logic                    big;
    logic                    all_zero;
    logic [REST_W-1:0]       e_min;
    logic [IM_W-1:0]         im_sel;
    logic signed [SUM_W-1:0] upd_sum;
    logic signed [VEL_W-1:0] upd_sat;
    logic                    upd_clip;
    logic signed [VEL_W-1:0] in_pos [3];
    logic signed [VEL_W-1:0] in_vel [3];

    assign in_pos = '{body.pos_x, body.pos_y, body.pos_z};
    assign in_vel = '{body.vel_x, body.vel_y, body.vel_z};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k]  = DIF_W'(in_pos[k]) - DIF_W'(pos0_reg[k]);
            dv_next[k] = DIF_W'(in_vel[k]) - DIF_W'(vel0_reg[k]);
        end
    end

    always_comb
    begin
        big      = 1'b0;
        all_zero = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            dmag_full[k] = d_reg[k][DIF_W-1] ? DIF_W'(-d_reg[k]) : DIF_W'(d_reg[k]);
            // A magnitude of 2^31 or more needs halving.
            if (dmag_full[k][DIF_W-1:DIF_W-2] != 2'b00)
                big = 1'b1;
            if (d_reg[k] != '0)
                all_zero = 1'b0;
        end
    end

    assign e_min = (rest0_reg < body.restitution) ? rest0_reg : body.restitution;

    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            pos0_reg  <= in_pos;
            vel0_reg  <= in_vel;
            rest0_reg <= body.restitution;
            im0_reg   <= body.inv_mass;
        end
        if (cmd.load_second)
        begin
            vel1_reg  <= in_vel;
            im1_reg   <= body.inv_mass;
            imsum_reg <= DVS_W'(im0_reg) + DVS_W'(body.inv_mass);
            onepe_reg <= (OPE_W'(1) << FRAC_BITS) + OPE_W'(e_min);
            d_reg     <= d_next;
            nv0_reg   <= vel0_reg;
            nv1_reg   <= in_vel;
            for (int k = 0; k < 3; k++)
            begin
                dvneg_reg[k] <= dv_next[k][DIF_W-1];
                dvmag_reg[k] <= dv_next[k][DIF_W-1] ? DIF_W'(-dv_next[k])
                                                    : DIF_W'(dv_next[k]);
            end
        end
        if (cmd.diff)
        begin
            // Halving keeps the squared length inside 64 bits.
            for (int k = 0; k < 3; k++)
            begin
                dmag_reg[k] <= big ? dmag_full[k][DIF_W-1:1] : dmag_full[k][DMAG_W-1:0];
                dneg_reg[k] <= d_reg[k][DIF_W-1];
            end
        end
        if (cmd.take_len)
            len_reg <= sq_root;
        if (cmd.take_n)
            nmag_reg[cmd.idx] <= div_quo[NW-1:0];
        if (cmd.take_vn)
            vn_reg <= acc_shr[VN_W-1:0];
        if (cmd.take_j)
            j_reg <= div_quo[JW-1:0];
        if (cmd.take_imp)
            imp_reg <= capped;
        if (cmd.take_dv)
        begin
            if (cmd.body)
                nv1_reg[cmd.idx] <= upd_sat;
            else
                nv0_reg[cmd.idx] <= upd_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            applied_reg <= 1'b0;
            c0_reg      <= 1'b0;
            c1_reg      <= 1'b0;
        end
        else if (cmd.load_second)
        begin
            applied_reg <= 1'b0;
            c0_reg      <= 1'b0;
            c1_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.take_j)
                applied_reg <= div_quo != '0;
            if (cmd.take_dv && upd_clip)
            begin
                if (cmd.body)
                    c1_reg <= 1'b1;
                else
                    c0_reg <= 1'b1;
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_sh  = 1'b0;
        op_neg = 1'b0;
        case (cmd.mop)
            MOP_SQ:
            begin
                op_a = MUL_W'(dmag_reg[cmd.idx]);
                op_b = MUL_W'(dmag_reg[cmd.idx]);
            end
            MOP_VN:
            begin
                op_a   = MUL_W'(nmag_reg[cmd.idx]);
                op_b   = MUL_W'(dvmag_reg[cmd.idx]);
                op_neg = dneg_reg[cmd.idx] ^ dvneg_reg[cmd.idx];
            end
            MOP_ONEPE:
            begin
                op_a = MUL_W'(onepe_reg);
                op_b = MUL_W'(vn_reg);
            end
            MOP_IMP_LO:
            begin
                op_a = MUL_W'(j_reg[31:0]);
                op_b = MUL_W'(nmag_reg[cmd.idx]);
            end
            MOP_IMP_HI:
            begin
                op_a  = MUL_W'(j_reg[JW-1:32]);
                op_b  = MUL_W'(nmag_reg[cmd.idx]);
                op_sh = 1'b1;
            end
            MOP_DV_LO:
            begin
                op_a = MUL_W'(imp_reg[31:0]);
                op_b = MUL_W'(im_sel);
            end
            MOP_DV_HI:
            begin
                op_a  = MUL_W'(imp_reg[CAP_W-1:32]);
                op_b  = MUL_W'(im_sel);
                op_sh = 1'b1;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign im_sel = cmd.body ? im1_reg : im0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= cmd.mul_en;
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign addend   = psh_reg ? (prod_ext << 32) : prod_ext;
    assign acc_base = pclr_reg ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= op_a * op_b;
            psh_reg  <= op_sh;
            pneg_reg <= op_neg;
            pclr_reg <= cmd.acc_clr;
        end
        if (pv_reg)
            acc_reg <= acc_base + (pneg_reg ? (~addend + 1'b1) : addend);
    end

    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_mag = acc_neg ? (~acc_reg + 1'b1) : acc_reg;
    assign acc_shr = acc_mag >> FRAC_BITS;
    assign capped  = (acc_shr > ACC_W'(MAG_CAP)) ? MAG_CAP : acc_shr[CAP_W-1:0];

    // Velocity update with the sign of the normal component, then saturation.
    always_comb
    begin
        if (cmd.body)
            upd_sum = SUM_W'(vel1_reg[cmd.idx])
                    + (dneg_reg[cmd.idx] ? -$signed(SUM_W'(capped)) : $signed(SUM_W'(capped)));
        else
            upd_sum = SUM_W'(vel0_reg[cmd.idx])
                    - (dneg_reg[cmd.idx] ? -$signed(SUM_W'(capped)) : $signed(SUM_W'(capped)));
        upd_clip = 1'b1;
        if (upd_sum > $signed(SUM_W'(32'sh7FFF_FFFF)))
            upd_sat = 32'sh7FFF_FFFF;
        else if (upd_sum < $signed(SUM_W'(-33'sh8000_0000)))
            upd_sat = -32'sh8000_0000;
        else
        begin
            upd_sat  = upd_sum[VEL_W-1:0];
            upd_clip = 1'b0;
        end
    end

    assign div_dividend = cmd.div_j ? acc_reg[DIV_W-1:0]
                                    : (DIV_W'(dmag_reg[cmd.idx]) << FRAC_BITS);
    assign div_divisor  = cmd.div_j ? imsum_reg : DVS_W'(len_reg);

    icr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .done     (div_done)
    );

    icr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg[SQ_W-1:0]),
        .root     (sq_root),
        .done     (sq_done)
    );

    assign sts.skip      = all_zero || (imsum_reg == '0);
    assign sts.vn_pos    = !acc_neg && (acc_shr != '0);
    assign sts.sqrt_done = sq_done;
    assign sts.div_done  = div_done;

    always_comb
    begin
        result.body_sel        = cmd.out_body;
        result.new_vel_x       = cmd.out_body ? nv1_reg[0] : nv0_reg[0];
        result.new_vel_y       = cmd.out_body ? nv1_reg[1] : nv0_reg[1];
        result.new_vel_z       = cmd.out_body ? nv1_reg[2] : nv0_reg[2];
        result.impulse_applied = applied_reg;
        result.clipped         = cmd.out_body ? c1_reg : c0_reg;
        result.last_of_pair    = cmd.out_body;
    end

    // A component can only saturate once a nonzero impulse has been computed.
    a_clip_needs_impulse: assert property (@(posedge clk) disable iff (!rst_n)
        (c0_reg || c1_reg) |-> applied_reg)
        else $error("clip flag set without an applied impulse");

endmodule

// ----- rtl/icr_ctrl.sv -----
// Sequencer that steps the datapath through one pair resolution.
`timescale 1ns / 1ps

module icr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          body_valid,
    output logic          body_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  icr_pkg::sts_t sts,
    output icr_pkg::cmd_t cmd
);
    import icr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DIFF = 13'b0000000000010,
        S_SQ   = 13'b0000000000100,
        S_SQRT = 13'b0000000001000,
        S_NDIV = 13'b0000000010000,
        S_VN   = 13'b0000000100000,
        S_JMUL = 13'b0000001000000,
        S_JDIV = 13'b0000010000000,
        S_IMP  = 13'b0000100000000,
        S_DV0  = 13'b0001000000000,
        S_DV1  = 13'b0010000000000,
        S_OUT0 = 13'b0100000000000,
        S_OUT1 = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] sub_reg, sub_next;
    logic [1:0] k_reg, k_next;
    logic       hf_reg, hf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= '0;
            k_reg     <= '0;
            hf_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            k_reg     <= k_next;
            hf_reg    <= hf_next;
        end
    end

    assign body_stall   = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT0) || (state_reg == S_OUT1);

    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        k_next     = k_reg;
        hf_next    = hf_reg;
        cmd        = '0;
        cmd.idx    = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (body_valid)
                begin
                    if (!hf_reg)
                    begin
                        cmd.load_first = 1'b1;
                        hf_next        = 1'b1;
                    end
                    else
                    begin
                        cmd.load_second = 1'b1;
                        hf_next         = 1'b0;
                        state_next      = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                cmd.diff = 1'b1;
                sub_next = '0;
                k_next   = '0;
                state_next = sts.skip ? S_OUT0 : S_SQ;
            end
            S_SQ, S_VN:
            begin
                // Three products issued back to back; the sum settles through the product and accumulator registers.
                cmd.mop     = (state_reg == S_SQ) ? MOP_SQ : MOP_VN;
                cmd.idx     = sub_reg[1:0];
                cmd.mul_en  = (sub_reg < 3'd3);
                cmd.acc_clr = (sub_reg == 3'd0);
                sub_next    = sub_reg + 1'b1;
                if (sub_reg == 3'd4)
                begin
                    sub_next = '0;
                    if (state_reg == S_SQ)
                        state_next = S_SQRT;
                    else
                    begin
                        cmd.take_vn = 1'b1;
                        state_next  = sts.vn_pos ? S_OUT0 : S_JMUL;
                    end
                end
            end
            S_SQRT:
            begin
                if (sub_reg == 3'd0)
                begin
                    cmd.sqrt_start = 1'b1;
                    sub_next       = 3'd1;
                end
                else if (sts.sqrt_done)
                begin
                    cmd.take_len = 1'b1;
                    sub_next     = '0;
                    k_next       = '0;
                    state_next   = S_NDIV;
                end
            end
            S_NDIV:
            begin
                if (sub_reg == 3'd0)
                begin
                    cmd.div_start = 1'b1;
                    sub_next      = 3'd1;
                end
                else if (sts.div_done)
                begin
                    cmd.take_n = 1'b1;
                    sub_next   = '0;
                    if (k_reg == 2'd2)
                        state_next = S_VN;
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            S_JMUL:
            begin
                cmd.mop     = MOP_ONEPE;
                cmd.mul_en  = (sub_reg == 3'd0);
                cmd.acc_clr = 1'b1;
                sub_next    = sub_reg + 1'b1;
                if (sub_reg == 3'd2)
                begin
                    sub_next   = '0;
                    state_next = S_JDIV;
                end
            end
            S_JDIV:
            begin
                cmd.div_j = 1'b1;
                if (sub_reg == 3'd0)
                begin
                    cmd.div_start = 1'b1;
                    sub_next      = 3'd1;
                end
                else if (sts.div_done)
                begin
                    cmd.take_j = 1'b1;
                    sub_next   = '0;
                    k_next     = '0;
                    state_next = S_IMP;
                end
            end
            S_IMP, S_DV0, S_DV1:
            begin
                // Low half then high half of a wide product, shifted and capped.
                cmd.body    = (state_reg == S_DV1);
                cmd.mul_en  = (sub_reg < 3'd2);
                cmd.acc_clr = (sub_reg == 3'd0);
                if (state_reg == S_IMP)
                    cmd.mop = (sub_reg == 3'd0) ? MOP_IMP_LO : MOP_IMP_HI;
                else
                    cmd.mop = (sub_reg == 3'd0) ? MOP_DV_LO : MOP_DV_HI;
                sub_next = sub_reg + 1'b1;
                if (sub_reg == 3'd3)
                begin
                    sub_next = '0;
                    if (state_reg == S_IMP)
                    begin
                        cmd.take_imp = 1'b1;
                        state_next   = S_DV0;
                    end
                    else if (state_reg == S_DV0)
                    begin
                        cmd.take_dv = 1'b1;
                        state_next  = S_DV1;
                    end
                    else
                    begin
                        cmd.take_dv = 1'b1;
                        if (k_reg == 2'd2)
                            state_next = S_OUT0;
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            state_next = S_IMP;
                        end
                    end
                end
            end
            S_OUT0:
            begin
                cmd.out_body = 1'b0;
                if (!result_stall)
                    state_next = S_OUT1;
            end
            S_OUT1:
            begin
                cmd.out_body = 1'b1;
                if (!result_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> body_stall)
        else $error("input taken while a result is pending");

    a_second_starts_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && body_valid && hf_reg) |=> (state_reg == S_DIFF && !hf_reg))
        else $error("second body did not start a resolution");

    a_pair_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT1 && !result_stall) |=> (state_reg == S_IDLE && !hf_reg))
        else $error("pair did not end in idle with no held body");

endmodule

// ----- rtl/impulse_collision_resolve.sv -----
// Top level of the impulse collision resolver.
`timescale 1ns / 1ps

//  channel   direction  payload        handshake
//  body      in         icr_pkg::in_t  body_valid / body_stall
//  result    out        icr_pkg::out_t result_valid / result_stall
//
//  The first body of a pair is held and gives no result.
//  The time from the second body to its first result offered is dominated by
//  one 32-step square root and four 64-step divisions on one shared divider.
//  Reset clears the held-body flag and the sequencer; stored bodies need no reset.
//  The input is stalled from the second body until both results are transferred.

module impulse_collision_resolve #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          body_valid,
    output logic          body_stall,
    input  icr_pkg::in_t  body,
    output logic          result_valid,
    input  logic          result_stall,
    output icr_pkg::out_t result
);
    import icr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    icr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .body_valid   (body_valid),
        .body_stall   (body_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    icr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .body   (body),
        .sts    (sts),
        .result (result)
    );

endmodule
